// ----- hdl/frids_pkg.sv -----
// Shared types and constants for the FIFO-replacement id set.
package frids_pkg;

    // Width of the capacity register and its value after reset.
    localparam int unsigned CAP_W = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // The operation that every cell of the chain performs.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_ROTATE
    } t_cell_op;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_state;

endpackage

// ----- hdl/frids_if.sv -----
// Request and response channel interfaces of the FIFO-replacement id set.
interface frids_req_if #(
    parameter int unsigned ID_WIDTH = 32
);
    logic                valid;
    logic                ready;
    logic                action;
    logic [ID_WIDTH-1:0] id_value;

    modport source (output valid, output action, output id_value, input ready);
    modport sink   (input valid, input action, input id_value, output ready);
endinterface

interface frids_rsp_if #(
    parameter int unsigned ID_WIDTH = 32,
    parameter int unsigned OCC_W    = 7
);
    logic                valid;
    logic                ready;
    logic                hit;
    logic                evicted_valid;
    logic [ID_WIDTH-1:0] evicted_id;
    logic                entry_valid;
    logic [ID_WIDTH-1:0] entry_id;
    logic [OCC_W-1:0]    occupancy;
    logic                last;

    modport source (output valid, output hit, output evicted_valid, output evicted_id,
                    output entry_valid, output entry_id, output occupancy, output last,
                    input ready);
    modport sink   (input valid, input hit, input evicted_valid, input evicted_id,
                    input entry_valid, input entry_id, input occupancy, input last,
                    output ready);
endinterface

// ----- hdl/fifo_replacement_id_set_core.sv -----
// Fully associative id set with FIFO replacement: a chain of cells holds the ids newest
// first, with the oldest stored id at the cell just below the occupancy. On an access, all
// cells compare in parallel, and on a miss the whole chain shifts by one with the new id
// entering the first cell, the oldest id falling out when the set is at capacity. A dump
// first enters the dump state, then gives one stored id per response while the output is
// free (an empty set answers with one invalid entry), reading the first cell while the
// stored cells rotate, so the order is restored when the dump ends; no request is taken
// during a dump. The user must write capacity through i_cfg_we / i_cfg_data only while the
// block is idle; the block does not enforce this. Zero acts as one and values above MAX_ENTRIES act as MAX_ENTRIES.
module fifo_replacement_id_set_core
    import frids_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 64,
    parameter int unsigned ID_WIDTH    = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    frids_req_if.sink        i_req,
    frids_rsp_if.source      o_rsp,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data
);

    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_ENTRIES);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_left, n_left;
    logic [CAP_W-1:0]    r_cap;

    logic                r_out_valid, n_out_valid;
    logic                r_hit, n_hit;
    logic                r_ev_valid, n_ev_valid;
    logic [ID_WIDTH-1:0] r_ev_id, n_ev_id;
    logic                r_en_valid, n_en_valid;
    logic [ID_WIDTH-1:0] r_en_id, n_en_id;
    logic [CNT_W-1:0]    r_occ, n_occ;
    logic                r_last, n_last;

    t_cell_op            w_op;
    logic                w_out_free;
    logic                w_req_ready;
    logic                w_hit;
    logic                w_evict;
    logic [CMP_W-1:0]    w_cap_ext;
    logic [CMP_W-1:0]    w_cap_eff;
    logic [ID_WIDTH-1:0] w_tail_id;
    logic [ID_WIDTH-1:0] w_ids   [MAX_ENTRIES];
    logic [ID_WIDTH-1:0] w_tails [MAX_ENTRIES];
    logic                w_match [MAX_ENTRIES];

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
            logic [ID_WIDTH-1:0] w_prev;
            logic [ID_WIDTH-1:0] w_next;
            if (g == 0) begin : g_first
                assign w_prev = i_req.id_value;
            end else begin : g_mid
                assign w_prev = w_ids[g-1];
            end
            if (g == MAX_ENTRIES - 1) begin : g_end
                assign w_next = w_ids[0];
            end else begin : g_inner
                assign w_next = w_ids[g+1];
            end
            frids_cell #(
                .ID_WIDTH (ID_WIDTH),
                .CNT_W    (CNT_W),
                .IDX      (g)
            ) u_cell (
                .i_clk     (i_clk),
                .i_op      (w_op),
                .i_count   (r_count),
                .i_key     (i_req.id_value),
                .i_prev_id (w_prev),
                .i_next_id (w_next),
                .i_wrap_id (w_ids[0]),
                .o_id      (w_ids[g]),
                .o_tail_id (w_tails[g]),
                .o_match   (w_match[g])
            );
        end
    endgenerate

    always_comb begin
        w_hit     = 1'b0;
        w_tail_id = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_hit     = w_hit | w_match[i];
            w_tail_id = w_tail_id | w_tails[i];
        end
    end

    assign w_cap_ext = CMP_W'(r_cap);
    assign w_cap_eff = (r_cap == '0) ? CMP_W'(1) : ((w_cap_ext > MAX_C) ? MAX_C : w_cap_ext);
    assign w_evict   = (CMP_W'(r_count) >= w_cap_eff);

    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_req_ready = (r_state == ST_IDLE) && w_out_free;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_hit       = r_hit;
        n_ev_valid  = r_ev_valid;
        n_ev_id     = r_ev_id;
        n_en_valid  = r_en_valid;
        n_en_id     = r_en_id;
        n_occ       = r_occ;
        n_last      = r_last;
        w_op        = CELL_HOLD;

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid && w_req_ready) begin
                    n_out_valid = 1'b1;
                    n_hit       = 1'b0;
                    n_ev_valid  = 1'b0;
                    n_ev_id     = '0;
                    n_en_valid  = 1'b0;
                    n_en_id     = '0;
                    n_occ       = r_count;
                    n_last      = 1'b1;
                    if (i_req.action) begin
                        // An empty set answers a dump with one invalid entry.
                        if (r_count != '0) begin
                            n_out_valid = 1'b0;
                            n_left      = r_count;
                            n_state     = ST_DUMP;
                        end
                    end else if (w_hit) begin
                        n_hit = 1'b1;
                    end else begin
                        w_op = CELL_SHIFT;
                        if (w_evict) begin
                            n_ev_valid = 1'b1;
                            n_ev_id    = w_tail_id;
                        end else begin
                            n_count = CNT_W'(r_count + 1'b1);
                            n_occ   = n_count;
                        end
                    end
                end
            end
            ST_DUMP: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_hit       = 1'b0;
                    n_ev_valid  = 1'b0;
                    n_ev_id     = '0;
                    n_en_valid  = 1'b1;
                    n_en_id     = w_ids[0];
                    n_occ       = r_count;
                    n_last      = (r_left == CNT_W'(1));
                    w_op        = CELL_ROTATE;
                    n_left      = CNT_W'(r_left - 1'b1);
                    if (r_left == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit      <= n_hit;
        r_ev_valid <= n_ev_valid;
        r_ev_id    <= n_ev_id;
        r_en_valid <= n_en_valid;
        r_en_id    <= n_en_id;
        r_occ      <= n_occ;
        r_last     <= n_last;
    end

    assign i_req.ready         = w_req_ready;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.hit           = r_hit;
    assign o_rsp.evicted_valid = r_ev_valid;
    assign o_rsp.evicted_id    = r_ev_id;
    assign o_rsp.entry_valid   = r_en_valid;
    assign o_rsp.entry_id      = r_en_id;
    assign o_rsp.occupancy     = r_occ;
    assign o_rsp.last          = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= MAX_C)
        else $error("occupancy exceeds the number of cells");

    a_no_request_in_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP) |-> !w_req_ready)
        else $error("request taken while a dump is running");

    a_count_stable_in_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP) |=> $stable(r_count))
        else $error("occupancy changed during a dump");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_hit && r_ev_valid) && !(r_en_valid && (r_hit || r_ev_valid)))
        else $error("response carries conflicting flags");

    a_dump_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP) |-> (r_left != '0) && (r_left <= r_count))
        else $error("dump counter out of range");

endmodule

// ----- hdl/frids_cell.sv -----
// One storage cell of the id chain: holds one id, compares it, shifts or rotates.
module frids_cell
    import frids_pkg::*;
#(
    parameter int unsigned ID_WIDTH = 32,
    parameter int unsigned CNT_W    = 7,
    parameter int unsigned IDX      = 0
) (
    input  logic                i_clk,
    input  t_cell_op            i_op,
    input  logic [CNT_W-1:0]    i_count,
    input  logic [ID_WIDTH-1:0] i_key,
    input  logic [ID_WIDTH-1:0] i_prev_id,
    input  logic [ID_WIDTH-1:0] i_next_id,
    input  logic [ID_WIDTH-1:0] i_wrap_id,
    output logic [ID_WIDTH-1:0] o_id,
    output logic [ID_WIDTH-1:0] o_tail_id,
    output logic                o_match
);

    localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(IDX + 1);

    logic [ID_WIDTH-1:0] r_id;
    logic [ID_WIDTH-1:0] n_id;
    logic                w_in_use;
    logic                w_is_tail;

    assign w_in_use  = (IDX_C < i_count);
    assign w_is_tail = (i_count == IDX_P1);

    always_comb begin
        case (i_op)
            CELL_SHIFT:  n_id = i_prev_id;
            CELL_ROTATE: n_id = w_is_tail ? i_wrap_id : i_next_id;
            default:     n_id = r_id;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

    assign o_id      = r_id;
    assign o_match   = w_in_use && (r_id == i_key);
    // Only the oldest stored cell drives the tail bus; the others give zero.
    assign o_tail_id = w_is_tail ? r_id : '0;

endmodule
